// ===== hw/rtl/gmid_pkg.sv =====
// Shared types, status codes and defaults for the grid marker id decoder.
`timescale 1ns / 1ps

package gmid_pkg;

    // Grid geometry and field widths
    localparam int GRID_SIZE      = 7;
    localparam int CELL_COUNT     = GRID_SIZE * GRID_SIZE;
    localparam int AREA_WIDTH     = 10;
    localparam int STATUS_WIDTH   = 3;
    localparam int ORIENT_WIDTH   = 2;
    localparam int CODE_WIDTH     = 9;
    localparam int NUMBER_WIDTH   = 5;
    localparam int POS_WIDTH      = 3;

    // Default width of the light pixel count
    localparam int DEFAULT_COUNT_WIDTH = 10;

    // Cell area after reset
    localparam logic [AREA_WIDTH-1:0] AREA_RESET = 10'd49;

    // Result status codes
    typedef enum logic [STATUS_WIDTH-1:0] {
        ST_OK       = 3'd0,
        ST_BORDER   = 3'd1,
        ST_MULTI    = 3'd2,
        ST_BADRING  = 3'd3,
        ST_NOORIENT = 3'd4,
        ST_PARITY   = 3'd5,
        ST_ZERO     = 3'd6
    } t_status;

    // Orientation codes
    typedef enum logic [ORIENT_WIDTH-1:0] {
        OR_TOP    = 2'd0,
        OR_RIGHT  = 2'd1,
        OR_BOTTOM = 2'd2,
        OR_LEFT   = 2'd3
    } t_orient;

    // Controller state, one-hot
    typedef enum logic [1:0] {
        S_ACCEPT = 2'b01,
        S_DECODE = 2'b10
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic store_cell;   // write the accepted word into the cell map
        logic load_result;  // decode the map into the output register
    } t_dp_cmd;

endpackage

// ===== hw/rtl/gmid_ctrl.sv =====
// Controller state machine: input and output handshakes, datapath commands.
`timescale 1ns / 1ps

module gmid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_final_cell,
    output logic              o_valid,
    input  logic              i_ready,
    output gmid_pkg::t_dp_cmd o_cmd
);

    gmid_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             w_in_take;
    logic             w_load;

    // Take words only out of reset and while no decode is pending
    assign o_ready   = i_rst_n && (r_state == gmid_pkg::S_ACCEPT);
    assign w_in_take = i_valid && o_ready;

    // Load a result once the output register is free or being emptied
    assign w_load = (r_state == gmid_pkg::S_DECODE) && (!r_out_valid || i_ready);

    assign o_cmd.store_cell  = w_in_take;
    assign o_cmd.load_result = w_load;
    assign o_valid           = r_out_valid;

    // Next state and output valid flag
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            gmid_pkg::S_ACCEPT: begin
                if (w_in_take && i_final_cell) begin
                    n_state = gmid_pkg::S_DECODE;
                end
            end
            gmid_pkg::S_DECODE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = gmid_pkg::S_ACCEPT;
                end
            end
            default: begin
                n_state = gmid_pkg::S_ACCEPT;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gmid_pkg::S_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== hw/rtl/gmid_datapath.sv =====
// Datapath: cell area register, dark map, border flag, decode and result register.
`timescale 1ns / 1ps

module gmid_datapath #(
    parameter int COUNT_WIDTH = gmid_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [gmid_pkg::AREA_WIDTH-1:0]     i_cfg_wr_data,
    input  gmid_pkg::t_dp_cmd                   i_cmd,
    input  logic [gmid_pkg::POS_WIDTH-1:0]      i_cell_column,
    input  logic [gmid_pkg::POS_WIDTH-1:0]      i_cell_row,
    input  logic [COUNT_WIDTH-1:0]              i_light_count,
    output logic [gmid_pkg::STATUS_WIDTH-1:0]   o_status,
    output logic [gmid_pkg::ORIENT_WIDTH-1:0]   o_orientation,
    output logic [gmid_pkg::CODE_WIDTH-1:0]     o_code_word,
    output logic [gmid_pkg::NUMBER_WIDTH-1:0]   o_marker_number
);

    localparam int AW     = gmid_pkg::AREA_WIDTH;
    localparam int CW     = gmid_pkg::CODE_WIDTH;
    localparam int NCELL  = gmid_pkg::CELL_COUNT;
    localparam int GS     = gmid_pkg::GRID_SIZE;
    localparam int MAXW   = (COUNT_WIDTH > AW) ? COUNT_WIDTH : AW;
    localparam int CMPW   = MAXW + 3;
    localparam int IDXW   = $clog2(NCELL);
    localparam int NRING  = 16;

    // Inner ring in scan order: column by column, top to bottom
    localparam int RING_X [NRING] = '{1, 1, 1, 1, 1, 2, 2, 3, 3, 4, 4, 5, 5, 5, 5, 5};
    localparam int RING_Y [NRING] = '{1, 2, 3, 4, 5, 1, 5, 1, 5, 1, 5, 1, 2, 3, 4, 5};
    localparam int RI_LEFT   = 2;
    localparam int RI_TOP    = 7;
    localparam int RI_BOTTOM = 8;
    localparam int RI_RIGHT  = 13;
    localparam logic [NRING-1:0] ORIENT_MASK =
        (NRING'(1) << RI_LEFT) | (NRING'(1) << RI_TOP) |
        (NRING'(1) << RI_BOTTOM) | (NRING'(1) << RI_RIGHT);

    // Parity group masks
    localparam logic [CW-1:0] PAR_A = 9'd341;
    localparam logic [CW-1:0] PAR_B = 9'd102;
    localparam logic [CW-1:0] PAR_C = 9'd120;
    localparam logic [CW-1:0] PAR_D = 9'd384;

    logic [AW-1:0]    r_cell_area;
    logic [NCELL-1:0] r_dark_map, n_dark_map;
    logic             r_border_fault, n_border_fault;

    logic                                 w_in_grid;
    logic                                 w_on_border;
    logic [IDXW-1:0]                      w_cell_idx;
    logic [CMPW-1:0]                      w_cnt_ext;
    logic [CMPW-1:0]                      w_half_area;
    logic [CMPW-1:0]                      w_cnt_x4;
    logic [CMPW-1:0]                      w_area_x3;
    logic                                 w_is_dark;
    logic                                 w_too_light;

    logic [NRING-1:0]                     w_ring;
    logic [NRING-1:0]                     w_first;
    logic                                 w_multi;
    logic [CW-1:0]                        w_code_top, w_code_right;
    logic [CW-1:0]                        w_code_bottom, w_code_left;
    logic [CW-1:0]                        w_code;
    logic [gmid_pkg::ORIENT_WIDTH-1:0]    w_orient;
    logic                                 w_parity_ok;
    logic [gmid_pkg::NUMBER_WIDTH-1:0]    w_number;
    logic [gmid_pkg::STATUS_WIDTH-1:0]    w_status;
    logic [gmid_pkg::ORIENT_WIDTH-1:0]    w_orient_out;
    logic [CW-1:0]                        w_code_out;
    logic [gmid_pkg::NUMBER_WIDTH-1:0]    w_number_out;

    function automatic logic [gmid_pkg::POS_WIDTH-1:0] POS_LIMIT();
        return gmid_pkg::POS_WIDTH'(GS);
    endfunction

    function automatic logic [gmid_pkg::POS_WIDTH-1:0] POS_EDGE();
        return gmid_pkg::POS_WIDTH'(GS - 1);
    endfunction

    // Classify the incoming cell
    assign w_in_grid   = (i_cell_column < POS_LIMIT()) && (i_cell_row < POS_LIMIT());
    assign w_on_border = (i_cell_column == '0) || (i_cell_row == '0) ||
                         (i_cell_column == POS_EDGE()) || (i_cell_row == POS_EDGE());
    assign w_cell_idx  = IDXW'(i_cell_row) * IDXW'(GS) + IDXW'(i_cell_column);
    assign w_cnt_ext   = CMPW'(i_light_count);
    assign w_half_area = CMPW'(r_cell_area >> 1);
    assign w_cnt_x4    = w_cnt_ext << 2;
    assign w_area_x3   = (CMPW'(r_cell_area) << 1) + CMPW'(r_cell_area);
    assign w_is_dark   = (w_cnt_ext < w_half_area);
    assign w_too_light = (w_cnt_x4 > w_area_x3);

    // Update the dark map and border flag
    always_comb begin
        n_dark_map     = r_dark_map;
        n_border_fault = r_border_fault;
        if (i_cmd.load_result) begin
            n_border_fault = 1'b0;
        end
        if (i_cmd.store_cell && w_in_grid) begin
            n_dark_map[w_cell_idx] = w_is_dark;
            if (w_on_border && w_too_light) begin
                n_border_fault = 1'b1;
            end
        end
    end

    // Gather the inner ring and read the code in all four rotations
    always_comb begin
        for (int k = 0; k < NRING; k++) begin
            w_ring[k] = r_dark_map[RING_Y[k] * GS + RING_X[k]];
        end
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                w_code_top[8 - (a * 3 + b)]    = r_dark_map[(2 + a) * GS + (2 + b)];
                w_code_right[8 - (a * 3 + b)]  = r_dark_map[(2 + b) * GS + (4 - a)];
                w_code_bottom[8 - (a * 3 + b)] = r_dark_map[(4 - a) * GS + (4 - b)];
                w_code_left[8 - (a * 3 + b)]   = r_dark_map[(4 - b) * GS + (2 + a)];
            end
        end
    end

    // First dark ring cell and whether there is more than one
    assign w_first = w_ring & (~w_ring + NRING'(1));
    assign w_multi = (w_ring & (w_ring - NRING'(1))) != '0;

    // Pick the orientation from the first dark ring cell
    always_comb begin
        priority if (w_first[RI_RIGHT]) begin
            w_orient = gmid_pkg::OR_RIGHT;
            w_code   = w_code_right;
        end else if (w_first[RI_BOTTOM]) begin
            w_orient = gmid_pkg::OR_BOTTOM;
            w_code   = w_code_bottom;
        end else if (w_first[RI_LEFT]) begin
            w_orient = gmid_pkg::OR_LEFT;
            w_code   = w_code_left;
        end else begin
            w_orient = gmid_pkg::OR_TOP;
            w_code   = w_code_top;
        end
    end

    assign w_parity_ok = !(^(w_code & PAR_A)) && !(^(w_code & PAR_B)) &&
                         !(^(w_code & PAR_C)) && !(^(w_code & PAR_D));
    assign w_number    = {w_code[8], w_code[6:4], w_code[2]};

    // Decide status in check order
    always_comb begin
        w_orient_out = '0;
        w_code_out   = '0;
        w_number_out = '0;
        priority if (r_border_fault) begin
            w_status = gmid_pkg::ST_BORDER;
        end else if (w_ring == '0) begin
            w_status = gmid_pkg::ST_NOORIENT;
        end else if ((w_first & ~ORIENT_MASK) != '0) begin
            w_status = gmid_pkg::ST_BADRING;
        end else if (w_multi) begin
            w_status = gmid_pkg::ST_MULTI;
        end else begin
            w_orient_out = w_orient;
            w_code_out   = w_code;
            priority if (!w_parity_ok) begin
                w_status = gmid_pkg::ST_PARITY;
            end else if (w_number == '0) begin
                w_status = gmid_pkg::ST_ZERO;
            end else begin
                w_status     = gmid_pkg::ST_OK;
                w_number_out = w_number;
            end
        end
    end

    // Control state: area register, dark map, border flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_area    <= gmid_pkg::AREA_RESET;
            r_dark_map     <= '0;
            r_border_fault <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cell_area <= i_cfg_wr_data;
            end
            r_dark_map     <= n_dark_map;
            r_border_fault <= n_border_fault;
        end
    end

    // Hold the result word until the next decode
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_result) begin
            o_status        <= w_status;
            o_orientation   <= w_orient_out;
            o_code_word     <= w_code_out;
            o_marker_number <= w_number_out;
        end
    end

endmodule

// ===== hw/rtl/grid_marker_id_decoder_core.sv =====
// Top level of the 7x7 grid marker id decoder: controller plus datapath.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one cell word per grid cell:
//   column, row, light pixel count and a final flag. Words with column or
//   row 7 change nothing but still trigger a decode when final.
//   Output channel (o_valid / i_ready) carries one result word per final
//   cell: status, orientation, raw 9-bit code and the 5-bit marker number.
//   Config: i_cfg_wr_en writes i_cfg_wr_data into the cell area register
//   at once; write it only while the block is idle.
//   Throughput: non-final words are taken one per cycle while no decode is
//   pending. After a final word the block enters the decode state, which
//   loads the decoded result into the output register from the registered
//   dark map once that register is free or being emptied; o_valid rises
//   then, and no words are taken in the decode state.
//   Stall: while a result waits, further non-final words are still taken;
//   a following final word holds in the decode state until the pending
//   result is taken, and o_ready stays low meanwhile.
//   Reset: cell area goes to 49, the dark map and border flag clear, and
//   no result is pending.
`timescale 1ns / 1ps

module grid_marker_id_decoder_core #(
    parameter int COUNT_WIDTH = gmid_pkg::DEFAULT_COUNT_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [gmid_pkg::AREA_WIDTH-1:0]     i_cfg_wr_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [gmid_pkg::POS_WIDTH-1:0]      i_cell_column,
    input  logic [gmid_pkg::POS_WIDTH-1:0]      i_cell_row,
    input  logic [COUNT_WIDTH-1:0]              i_light_count,
    input  logic                                i_final_cell,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [gmid_pkg::STATUS_WIDTH-1:0]   o_status,
    output logic [gmid_pkg::ORIENT_WIDTH-1:0]   o_orientation,
    output logic [gmid_pkg::CODE_WIDTH-1:0]     o_code_word,
    output logic [gmid_pkg::NUMBER_WIDTH-1:0]   o_marker_number
);

    gmid_pkg::t_dp_cmd w_cmd;

    // Sequence the handshakes
    gmid_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_final_cell (i_final_cell),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_cmd        (w_cmd)
    );

    // Store cells and decode
    gmid_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_cmd           (w_cmd),
        .i_cell_column   (i_cell_column),
        .i_cell_row      (i_cell_row),
        .i_light_count   (i_light_count),
        .o_status        (o_status),
        .o_orientation   (o_orientation),
        .o_code_word     (o_code_word),
        .o_marker_number (o_marker_number)
    );

endmodule

// ===== verif/grid_marker_id_decoder_core_test.sv =====
// Self-checking testbench for the grid marker id decoder core: directed table, random markers.
`timescale 1ns / 1ps

module grid_marker_id_decoder_core_test;

    localparam int HALF_PERIOD = 1;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD = 300;
    localparam int MAX_PRINTS = 20;

    // Even-parity groups over the 9-bit code word
    localparam logic [gmid_pkg::CODE_WIDTH-1:0] PAR_GROUP_A = 9'd341;
    localparam logic [gmid_pkg::CODE_WIDTH-1:0] PAR_GROUP_B = 9'd102;
    localparam logic [gmid_pkg::CODE_WIDTH-1:0] PAR_GROUP_C = 9'd120;
    localparam logic [gmid_pkg::CODE_WIDTH-1:0] PAR_GROUP_D = 9'd384;

    typedef struct packed {
        logic [gmid_pkg::POS_WIDTH-1:0]           col;
        logic [gmid_pkg::POS_WIDTH-1:0]           row;
        logic [gmid_pkg::DEFAULT_COUNT_WIDTH-1:0] cnt;
        logic                                     fin;
    } t_cell_word;

    typedef struct packed {
        gmid_pkg::t_status                 status;
        gmid_pkg::t_orient                 orient;
        logic [gmid_pkg::CODE_WIDTH-1:0]   code;
        logic [gmid_pkg::NUMBER_WIDTH-1:0] number;
    } t_marker_result;

    // One word to send, with a hand-written result where the table gives one
    typedef struct packed {
        t_cell_word     word;
        logic           has_fixed;
        t_marker_result fixed;
    } t_feed_item;

    logic                                     i_clk = 1'b0;
    logic                                     i_rst_n = 1'b0;
    logic                                     i_cfg_wr_en = 1'b0;
    logic [gmid_pkg::AREA_WIDTH-1:0]          i_cfg_wr_data = '0;
    logic                                     i_valid = 1'b0;
    logic                                     o_ready;
    logic [gmid_pkg::POS_WIDTH-1:0]           i_cell_column = '0;
    logic [gmid_pkg::POS_WIDTH-1:0]           i_cell_row = '0;
    logic [gmid_pkg::DEFAULT_COUNT_WIDTH-1:0] i_light_count = '0;
    logic                                     i_final_cell = 1'b0;
    logic                                     o_valid;
    logic                                     i_ready = 1'b0;
    logic [gmid_pkg::STATUS_WIDTH-1:0]        o_status;
    logic [gmid_pkg::ORIENT_WIDTH-1:0]        o_orientation;
    logic [gmid_pkg::CODE_WIDTH-1:0]          o_code_word;
    logic [gmid_pkg::NUMBER_WIDTH-1:0]        o_marker_number;

    // Predictor state
    logic [gmid_pkg::CELL_COUNT-1:0] dark_cells = '0;
    bit                              border_hit = 1'b0;
    logic [gmid_pkg::AREA_WIDTH-1:0] area_model = gmid_pkg::AREA_RESET;

    t_feed_item     cell_feed[$];
    t_feed_item     marker_table[$];
    t_feed_item     offered_item = '0;
    t_marker_result decodes_pending[$];

    int unsigned send_idle_pct = 0;
    int unsigned take_stall_pct = 0;
    int unsigned hold_left = 0;
    int unsigned cells_queued = 0;
    int unsigned cells_accepted = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned status_tally[8] = '{default: 0};

    grid_marker_id_decoder_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cell_column   (i_cell_column),
        .i_cell_row      (i_cell_row),
        .i_light_count   (i_light_count),
        .i_final_cell    (i_final_cell),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_orientation   (o_orientation),
        .o_code_word     (o_code_word),
        .o_marker_number (o_marker_number)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Grid index of code cell (a, b) as read in the given rotation
    function automatic int unsigned code_cell(gmid_pkg::t_orient o, int unsigned a,
                                              int unsigned b);
        case (o)
            gmid_pkg::OR_TOP:    return (2 + a) * gmid_pkg::GRID_SIZE + (2 + b);
            gmid_pkg::OR_RIGHT:  return (2 + b) * gmid_pkg::GRID_SIZE + (4 - a);
            gmid_pkg::OR_BOTTOM: return (4 - a) * gmid_pkg::GRID_SIZE + (4 - b);
            default:             return (4 - b) * gmid_pkg::GRID_SIZE + (2 + a);
        endcase
    endfunction

    // Apply one cell word to the predicted grid; return 1 with the decode on a final word
    function automatic bit grid_cell_update(input t_cell_word w, output t_marker_result r);
        int unsigned idx, x, y, a, b;
        bit found;
        gmid_pkg::t_status st;
        gmid_pkg::t_orient ori;
        logic [gmid_pkg::CODE_WIDTH-1:0] code;
        logic [gmid_pkg::NUMBER_WIDTH-1:0] number;
        found = 1'b0;
        st = gmid_pkg::ST_OK;
        ori = gmid_pkg::OR_TOP;
        code = '0;
        number = '0;
        r = '0;
        // Update the cell, positions of 7 change nothing
        if (w.col < gmid_pkg::GRID_SIZE && w.row < gmid_pkg::GRID_SIZE) begin
            idx = w.row * gmid_pkg::GRID_SIZE + w.col;
            dark_cells[idx] = (int'(w.cnt) < int'(area_model >> 1));
            if ((w.col == 0 || w.col == gmid_pkg::GRID_SIZE - 1 || w.row == 0 ||
                 w.row == gmid_pkg::GRID_SIZE - 1)
                && 4 * int'(w.cnt) > 3 * int'(area_model))
                border_hit = 1'b1;
        end
        if (!w.fin)
            return 1'b0;
        if (border_hit) begin
            st = gmid_pkg::ST_BORDER;
        end else begin
            // Scan the inner ring column by column, first error wins
            for (x = 1; x <= 5; x++) begin
                for (y = 1; y <= 5; y++) begin
                    if (x != 1 && x != 5 && y != 1 && y != 5)
                        continue;
                    if (st != gmid_pkg::ST_OK || !dark_cells[y * gmid_pkg::GRID_SIZE + x])
                        continue;
                    if (found)
                        st = gmid_pkg::ST_MULTI;
                    else if (x == 3 && y == 1) begin
                        ori = gmid_pkg::OR_TOP;
                        found = 1'b1;
                    end else if (x == 5 && y == 3) begin
                        ori = gmid_pkg::OR_RIGHT;
                        found = 1'b1;
                    end else if (x == 3 && y == 5) begin
                        ori = gmid_pkg::OR_BOTTOM;
                        found = 1'b1;
                    end else if (x == 1 && y == 3) begin
                        ori = gmid_pkg::OR_LEFT;
                        found = 1'b1;
                    end else
                        st = gmid_pkg::ST_BADRING;
                end
            end
            if (st == gmid_pkg::ST_OK && !found)
                st = gmid_pkg::ST_NOORIENT;
            if (st == gmid_pkg::ST_OK) begin
                for (a = 0; a < 3; a++)
                    for (b = 0; b < 3; b++)
                        code = {code[gmid_pkg::CODE_WIDTH-2:0],
                                dark_cells[code_cell(ori, a, b)]};
                if ((^(code & PAR_GROUP_A)) || (^(code & PAR_GROUP_B)) ||
                    (^(code & PAR_GROUP_C)) || (^(code & PAR_GROUP_D))) begin
                    st = gmid_pkg::ST_PARITY;
                end else begin
                    number = {code[8], code[6:4], code[2]};
                    if (number == 0)
                        st = gmid_pkg::ST_ZERO;
                end
            end else begin
                ori = gmid_pkg::OR_TOP;
            end
        end
        if (st != gmid_pkg::ST_OK)
            number = '0;
        border_hit = 1'b0;
        r.status = st;
        r.orient = ori;
        r.code = code;
        r.number = number;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic queue_word(input int unsigned col, input int unsigned row,
                              input int unsigned cnt, input bit fin);
        t_feed_item it;
        it = '0;
        it.word.col = gmid_pkg::POS_WIDTH'(col);
        it.word.row = gmid_pkg::POS_WIDTH'(row);
        it.word.cnt = gmid_pkg::DEFAULT_COUNT_WIDTH'(cnt);
        it.word.fin = fin;
        cell_feed = {cell_feed, it};
        cells_queued++;
    endtask

    // Directed row; typed means the expected decode is written in the row
    task automatic table_row(input int unsigned col, input int unsigned row,
                             input int unsigned cnt, input bit fin, input bit typed,
                             input gmid_pkg::t_status st, input gmid_pkg::t_orient ori,
                             input int unsigned code, input int unsigned number);
        t_feed_item it;
        it = '0;
        it.word.col = gmid_pkg::POS_WIDTH'(col);
        it.word.row = gmid_pkg::POS_WIDTH'(row);
        it.word.cnt = gmid_pkg::DEFAULT_COUNT_WIDTH'(cnt);
        it.word.fin = fin;
        it.has_fixed = typed;
        it.fixed.status = st;
        it.fixed.orient = ori;
        it.fixed.code = gmid_pkg::CODE_WIDTH'(code);
        it.fixed.number = gmid_pkg::NUMBER_WIDTH'(number);
        marker_table = {marker_table, it};
    endtask

    // Word at column 7 or row 7, which the block ignores apart from a final decode
    task automatic push_stray(input bit fin);
        if ($urandom_range(1, 0))
            queue_word(gmid_pkg::GRID_SIZE, $urandom_range(7, 0), $urandom_range(1023, 0), fin);
        else
            queue_word($urandom_range(6, 0), gmid_pkg::GRID_SIZE, $urandom_range(1023, 0), fin);
    endtask

    task automatic queue_noise(input int unsigned n, input int unsigned fin_pct);
        int unsigned i;
        for (i = 0; i < n; i++)
            queue_word($urandom_range(7, 0), $urandom_range(7, 0), $urandom_range(1023, 0),
                       $urandom_range(99, 0) < fin_pct);
    endtask

    // Build a well-formed marker with random id and rotation, sometimes damaged
    task automatic queue_marker();
        int unsigned order[gmid_pkg::CELL_COUNT];
        int unsigned i, j, k, tmp, a, b, x, y, half, cnt;
        logic [gmid_pkg::CELL_COUNT-1:0] dark, hot;
        logic [gmid_pkg::NUMBER_WIDTH-1:0] id;
        logic [gmid_pkg::CODE_WIDTH-1:0] code;
        gmid_pkg::t_orient ori;
        bit skip_cell, stray_word, stray_final;
        half = area_model >> 1;
        dark = '0;
        hot = '0;
        // Dark border all round
        for (i = 0; i < gmid_pkg::CELL_COUNT; i++) begin
            x = i % gmid_pkg::GRID_SIZE;
            y = i / gmid_pkg::GRID_SIZE;
            if (x == 0 || x == gmid_pkg::GRID_SIZE - 1 || y == 0 ||
                y == gmid_pkg::GRID_SIZE - 1)
                dark[i] = 1'b1;
        end
        // Overexpose one border cell now and then
        if ($urandom_range(9, 0) == 0) begin
            x = $urandom_range(6, 0);
            y = $urandom_range(1, 0) ? 0 : 6;
            if ($urandom_range(1, 0)) begin
                tmp = x;
                x = y;
                y = tmp;
            end
            hot[y * gmid_pkg::GRID_SIZE + x] = 1'b1;
            dark[y * gmid_pkg::GRID_SIZE + x] = 1'b0;
        end
        // Orientation cell, missing once in a while
        ori = gmid_pkg::t_orient'($urandom_range(3, 0));
        if ($urandom_range(19, 0) != 0) begin
            case (ori)
                gmid_pkg::OR_TOP:    dark[1 * gmid_pkg::GRID_SIZE + 3] = 1'b1;
                gmid_pkg::OR_RIGHT:  dark[3 * gmid_pkg::GRID_SIZE + 5] = 1'b1;
                gmid_pkg::OR_BOTTOM: dark[5 * gmid_pkg::GRID_SIZE + 3] = 1'b1;
                default:             dark[3 * gmid_pkg::GRID_SIZE + 1] = 1'b1;
            endcase
        end
        // Extra dark ring cell now and then
        if ($urandom_range(9, 0) == 0) begin
            x = $urandom_range(5, 1);
            y = (x == 1 || x == 5) ? $urandom_range(5, 1) : ($urandom_range(1, 0) ? 1 : 5);
            dark[y * gmid_pkg::GRID_SIZE + x] = 1'b1;
        end
        // Encode the id with its parity bits, flip one bit sometimes
        id = gmid_pkg::NUMBER_WIDTH'($urandom);
        code[8] = id[4];
        code[6:4] = id[3:1];
        code[2] = id[0];
        code[7] = code[8];
        code[3] = ^code[6:4];
        code[1] = code[2] ^ code[5] ^ code[6];
        code[0] = code[2] ^ code[4] ^ code[6] ^ code[8];
        if ($urandom_range(6, 0) == 0) begin
            j = $urandom_range(8, 0);
            code[j] = ~code[j];
        end
        for (a = 0; a < 3; a++)
            for (b = 0; b < 3; b++)
                dark[code_cell(ori, a, b)] = code[8 - (a * 3 + b)];
        // Shuffle the send order
        for (i = 0; i < gmid_pkg::CELL_COUNT; i++)
            order[i] = i;
        for (i = gmid_pkg::CELL_COUNT - 1; i > 0; i--) begin
            j = $urandom_range(i, 0);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        skip_cell = ($urandom_range(9, 0) == 0);
        stray_word = ($urandom_range(7, 0) == 0);
        stray_final = ($urandom_range(7, 0) == 0);
        for (i = 0; i < gmid_pkg::CELL_COUNT; i++) begin
            k = order[i];
            if (stray_word && i == gmid_pkg::CELL_COUNT / 2)
                push_stray(1'b0);
            // Leave one cell stale from the previous marker
            if (skip_cell && i == 0)
                continue;
            if (hot[k])
                cnt = $urandom_range(1023, (3 * area_model) / 4 + 1);
            else if (dark[k])
                cnt = (half != 0) ? $urandom_range(half - 1, 0) : 0;
            else
                cnt = $urandom_range(1023, half);
            queue_word(k % gmid_pkg::GRID_SIZE, k / gmid_pkg::GRID_SIZE, cnt,
                       i == gmid_pkg::CELL_COUNT - 1 && !stray_final);
        end
        if (stray_final)
            push_stray(1'b1);
    endtask

    task automatic write_cell_area(input logic [gmid_pkg::AREA_WIDTH-1:0] v);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        area_model = v;
    endtask

    // Wait until every word is taken and every decode has come back
    task automatic drain();
        @(negedge i_clk);
        while (cells_accepted != cells_queued || decodes_pending.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [gmid_pkg::AREA_WIDTH-1:0] area,
                             input int unsigned idle,
                             input int unsigned stall, input int unsigned n);
        int unsigned m;
        write_cell_area(area);
        send_idle_pct = idle;
        take_stall_pct = stall;
        for (m = 0; m < n; m++) begin
            if ($urandom_range(4, 0) == 0)
                queue_noise($urandom_range(12, 1), 25);
            else
                queue_marker();
        end
        drain();
    endtask

    // Offer cell words; hold a word until it is taken
    always @(posedge i_clk) begin : cell_sender
        t_feed_item nxt;
        if (i_valid && !o_ready) begin
            // hold
        end else if (cell_feed.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            nxt = cell_feed[0];
            cell_feed.delete(0);
            offered_item <= nxt;
            i_valid <= 1'b1;
            i_cell_column <= nxt.word.col;
            i_cell_row <= nxt.word.row;
            i_light_count <= nxt.word.cnt;
            i_final_cell <= nxt.word.fin;
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Drive ready for results, with an optional long hold-off
    always @(posedge i_clk) begin : result_taker
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99, 0) >= take_stall_pct);
        end
    end

    // Check results against the oldest pending decode, predict on accepted words
    always @(posedge i_clk) begin : marker_checker
        t_marker_result want, calc, due;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                results_seen++;
                status_tally[o_status]++;
                if (decodes_pending.size() == 0) begin
                    report_mismatch("result with no decode pending", o_status, 0);
                end else begin
                    want = decodes_pending[0];
                    decodes_pending.delete(0);
                    if (o_status !== want.status)
                        report_mismatch("status", o_status, want.status);
                    if (o_orientation !== want.orient)
                        report_mismatch("orientation", o_orientation, want.orient);
                    if (o_code_word !== want.code)
                        report_mismatch("code_word", o_code_word, want.code);
                    if (o_marker_number !== want.number)
                        report_mismatch("marker_number", o_marker_number, want.number);
                end
            end
            if (i_valid && o_ready) begin
                cells_accepted++;
                if (grid_cell_update(offered_item.word, calc)) begin
                    due = offered_item.has_fixed ? offered_item.fixed : calc;
                    decodes_pending = {decodes_pending, due};
                end
            end
        end
    end

    initial begin : main_sequence
        int unsigned i;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table at the reset area of 49 (dark below 24, border fault above 36)
        // empty grid after reset
        table_row(7, 7, 0,    1, 1, gmid_pkg::ST_NOORIENT, gmid_pkg::OR_TOP, 0, 0);
        // bright corner
        table_row(0, 0, 1023, 1, 1, gmid_pkg::ST_BORDER,   gmid_pkg::OR_TOP, 0, 0);
        table_row(3, 1, 0,    0, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        // column out of range
        table_row(7, 3, 0,    0, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        // row out of range
        table_row(3, 7, 1023, 0, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        // top mark, empty code
        table_row(7, 7, 1023, 1, 1, gmid_pkg::ST_ZERO,     gmid_pkg::OR_TOP, 0, 0);
        // top and right marks
        table_row(5, 3, 0,    1, 1, gmid_pkg::ST_MULTI,    gmid_pkg::OR_TOP, 0, 0);
        table_row(5, 3, 1023, 0, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        // dark ring corner
        table_row(1, 1, 23,   1, 1, gmid_pkg::ST_BADRING,  gmid_pkg::OR_TOP, 0, 0);
        // just light
        table_row(1, 1, 24,   0, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        table_row(2, 2, 23,   1, 1, gmid_pkg::ST_PARITY,   gmid_pkg::OR_TOP, 256, 0);
        table_row(3, 2, 0,    0, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        table_row(4, 4, 0,    1, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        // border just inside limit
        table_row(6, 6, 36,   1, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        // border just over limit
        table_row(6, 0, 37,   1, 1, gmid_pkg::ST_BORDER,   gmid_pkg::OR_TOP, 0, 0);
        table_row(3, 1, 1023, 0, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        // right rotation
        table_row(5, 3, 5,    1, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        table_row(5, 3, 1023, 0, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        // bottom rotation
        table_row(3, 5, 0,    1, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        table_row(3, 5, 1023, 0, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        // left rotation
        table_row(1, 3, 0,    1, 0, gmid_pkg::ST_OK,       gmid_pkg::OR_TOP, 0, 0);
        for (i = 0; i < marker_table.size(); i++) begin
            cell_feed = {cell_feed, marker_table[i]};
            cells_queued++;
        end
        drain();

        // Random markers across areas and idle mixes
        run_phase(10'd1023, 0, 0, 4);
        run_phase(10'd1, 52, 0, 2);
        run_phase(gmid_pkg::AREA_WIDTH'($urandom_range(1022, 2)), 0, 52, 4);
        run_phase(10'd0, 14, 14, 2);

        // Hold results off for a long stretch while words keep coming
        write_cell_area(gmid_pkg::AREA_RESET);
        send_idle_pct = 0;
        take_stall_pct = 0;
        @(negedge i_clk);
        hold_left = LONG_HOLD;
        queue_noise(60, 30);
        queue_marker();
        queue_marker();
        // Wait until every word is taken and every decode is back
        drain();

        run_phase(gmid_pkg::AREA_WIDTH'($urandom_range(1022, 2)), 14, 14, 4);
        run_phase(10'd16, 52, 52, 2);

        drain();
        $display("sent %0d cell words over areas 49, 1023, 1, 0, 16 and two random; %0d results",
                 cells_accepted, results_seen);
        $display("status mix: ok %0d border %0d multi %0d bad ring %0d none %0d parity %0d zero %0d",
                 status_tally[gmid_pkg::ST_OK], status_tally[gmid_pkg::ST_BORDER],
                 status_tally[gmid_pkg::ST_MULTI], status_tally[gmid_pkg::ST_BADRING],
                 status_tally[gmid_pkg::ST_NOORIENT], status_tally[gmid_pkg::ST_PARITY],
                 status_tally[gmid_pkg::ST_ZERO]);
        if (mismatch_count == 0 && decodes_pending.size() == 0)
            $display("grid_marker_id_decoder_core_test: PASS");
        else
            $display("grid_marker_id_decoder_core_test: FAIL");
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #2_000_000;
        $display("timeout with %0d decodes pending", decodes_pending.size());
        $display("grid_marker_id_decoder_core_test: FAIL");
        $finish;
    end

endmodule
